FILE: rtl/oscd_pkg.sv
package oscd_pkg;

  // Speeds with a magnitude below this count as a stop
  localparam int unsigned DEADBAND = 4;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned LIMIT_W = 14;
  localparam int unsigned MAXSP_W = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SPEED = 2'd2;

  // Register reset values
  localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST   = 14'd6631;
  localparam logic [MAXSP_W-1:0] MAX_SPEED_RST     = 15'd4915;
  localparam logic [SPEED_W-1:0] INITIAL_SPEED_RST = 16'd0;

  typedef struct packed {
    logic [LIMIT_W-1:0]        angle_limit;
    logic [MAXSP_W-1:0]        max_speed;
    logic signed [SPEED_W-1:0] initial_speed;
  } cfg_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] velocity;
    logic signed [ANGLE_W-1:0] held_angle;
    logic                      dir_pos;
  } motion_t;

  // Apply one speed command to the motion state
  function automatic motion_t apply_speed(input motion_t st,
                                          input logic signed [SPEED_W-1:0] s,
                                          input logic signed [ANGLE_W-1:0] angle,
                                          input logic [MAXSP_W-1:0] max_speed);
    motion_t                   nx;
    logic signed [SPEED_W:0]   s_ext;
    logic [SPEED_W:0]          s_mag;
    logic signed [SPEED_W-1:0] sz;
    logic signed [SPEED_W-1:0] lim;
    logic signed [SPEED_W-1:0] lim_n;
    logic signed [SPEED_W-1:0] v;
    nx    = st;
    s_ext = {s[SPEED_W-1], s};
    s_mag = s_ext[SPEED_W] ? unsigned'(-s_ext) : unsigned'(s_ext);
    sz    = s;
    if (s_mag < (SPEED_W+1)'(DEADBAND)) begin
      sz            = '0;
      nx.held_angle = angle;
    end
    // Remember the direction when motion stops
    if (st.velocity != '0 && sz == '0) begin
      nx.dir_pos = ~st.velocity[SPEED_W-1];
    end
    lim   = $signed({1'b0, max_speed});
    lim_n = -lim;
    if (sz > 0) begin
      v = (sz < lim) ? sz : lim;
    end else begin
      v = (sz > lim_n) ? sz : lim_n;
    end
    // Resume the stored direction after a stop
    if (st.velocity == '0 && sz != '0 && !st.dir_pos) begin
      v = -v;
    end
    nx.velocity = v;
    return nx;
  endfunction

endpackage

FILE: rtl/oscd_step.sv
module oscd_step (
  input  oscd_pkg::cfg_t                       cfg_i,
  input  oscd_pkg::motion_t                    state_i,
  input  logic signed [oscd_pkg::ANGLE_W-1:0]  joint_angle_i,
  input  logic signed [oscd_pkg::SPEED_W-1:0]  speed_cmd_i,
  input  logic                                 time_back_i,
  output oscd_pkg::motion_t                    state_o,
  output logic signed [oscd_pkg::SPEED_W-1:0]  velocity_drive_o,
  output logic                                 override_valid_o,
  output logic signed [oscd_pkg::ANGLE_W-1:0]  position_value_o
);

  oscd_pkg::motion_t                   ctl_st;
  logic signed [oscd_pkg::SPEED_W-1:0] vel_mag;
  logic signed [oscd_pkg::ANGLE_W-1:0] lim;
  logic signed [oscd_pkg::ANGLE_W-1:0] lim_n;
  logic signed [oscd_pkg::SPEED_W-1:0] cmd_s;
  logic signed [oscd_pkg::ANGLE_W-1:0] cmd_angle;

  assign vel_mag = state_i.velocity[oscd_pkg::SPEED_W-1] ? -state_i.velocity
                                                         : state_i.velocity;
  assign lim   = $signed({2'b00, cfg_i.angle_limit});
  assign lim_n = -lim;

  // Control phase: time jump, hold, or reverse at the limits
  always_comb begin
    ctl_st           = state_i;
    override_valid_o = 1'b0;
    position_value_o = '0;
    if (time_back_i) begin
      ctl_st = oscd_pkg::apply_speed(state_i, cfg_i.initial_speed, joint_angle_i,
                                     cfg_i.max_speed);
      ctl_st.held_angle = '0;
      ctl_st.dir_pos    = 1'b1;
      override_valid_o  = 1'b1;
      velocity_drive_o  = cfg_i.initial_speed;
    end else begin
      priority if (state_i.velocity == '0) begin
        override_valid_o = 1'b1;
        position_value_o = state_i.held_angle;
      end else if (joint_angle_i >= lim) begin
        ctl_st.velocity = -vel_mag;
      end else if (joint_angle_i <= lim_n) begin
        ctl_st.velocity = vel_mag;
      end else begin
        ctl_st.velocity = state_i.velocity;
      end
      velocity_drive_o = ctl_st.velocity;
    end
  end

  // Command phase: speed command (negative values taken as zero), signed by the updated motion direction
  always_comb begin
    cmd_s = speed_cmd_i[oscd_pkg::SPEED_W-1] ? '0 : speed_cmd_i;
    if (ctl_st.velocity[oscd_pkg::SPEED_W-1]) begin
      cmd_s = -cmd_s;
    end
    cmd_angle = override_valid_o ? position_value_o : joint_angle_i;
    state_o   = oscd_pkg::apply_speed(ctl_st, cmd_s, cmd_angle, cfg_i.max_speed);
  end

endmodule

FILE: rtl/oscillating_scan_direction_control.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid_i/in_stall_o | joint_angle, speed_cmd, time_back
// out     | output    | out_valid_o/out_stall_i | velocity_drive, override_valid,
//         |           |                       | position_value
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle while the input is not stalled; its result appears in the output
// register in the cycle after the transfer, from the single control/command pass between state and output.
// Reset clears the motion state (stopped, held angle 0, positive direction) and
// loads the register defaults. The input stalls only while a result is held
// waiting on out_stall_i; a new item is taken in the cycle the result leaves.
module oscillating_scan_direction_control (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [oscd_pkg::ANGLE_W-1:0]    joint_angle_i,
  input  logic signed [oscd_pkg::SPEED_W-1:0]    speed_cmd_i,
  input  logic                                   time_back_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [oscd_pkg::SPEED_W-1:0]    velocity_drive_o,
  output logic                                   override_valid_o,
  output logic signed [oscd_pkg::ANGLE_W-1:0]    position_value_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [oscd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [oscd_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  oscd_pkg::cfg_t                      cfg_q;
  oscd_pkg::motion_t                   state_q;
  oscd_pkg::motion_t                   state_d;
  logic                                out_valid_q;
  logic signed [oscd_pkg::SPEED_W-1:0] drive_d;
  logic signed [oscd_pkg::SPEED_W-1:0] drive_q;
  logic                                ovr_d;
  logic                                ovr_q;
  logic signed [oscd_pkg::ANGLE_W-1:0] pos_d;
  logic signed [oscd_pkg::ANGLE_W-1:0] pos_q;
  logic                                in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_xfer     = in_valid_i & ~in_stall_o;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.angle_limit   <= oscd_pkg::ANGLE_LIMIT_RST;
      cfg_q.max_speed     <= oscd_pkg::MAX_SPEED_RST;
      cfg_q.initial_speed <= $signed(oscd_pkg::INITIAL_SPEED_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        oscd_pkg::REG_ANGLE_LIMIT:
          cfg_q.angle_limit <= cfg_data_i[oscd_pkg::LIMIT_W-1:0];
        oscd_pkg::REG_MAX_SPEED:
          cfg_q.max_speed <= cfg_data_i[oscd_pkg::MAXSP_W-1:0];
        oscd_pkg::REG_INITIAL_SPEED:
          cfg_q.initial_speed <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  oscd_step u_step (
    .cfg_i            (cfg_q),
    .state_i          (state_q),
    .joint_angle_i    (joint_angle_i),
    .speed_cmd_i      (speed_cmd_i),
    .time_back_i      (time_back_i),
    .state_o          (state_d),
    .velocity_drive_o (drive_d),
    .override_valid_o (ovr_d),
    .position_value_o (pos_d)
  );

  // Advance motion state on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.velocity   <= '0;
      state_q.held_angle <= '0;
      state_q.dir_pos    <= 1'b1;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Hold the result until the output transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      drive_q <= drive_d;
      ovr_q   <= ovr_d;
      pos_q   <= pos_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign velocity_drive_o = drive_q;
  assign override_valid_o = ovr_q;
  assign position_value_o = pos_q;

endmodule

FILE: verif/oscillating_scan_direction_control_tb.sv
module oscillating_scan_direction_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [oscd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 4;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_e;

  typedef struct packed {
    logic signed [oscd_pkg::SPEED_W-1:0] drive;
    logic                                ovr;
    logic signed [oscd_pkg::ANGLE_W-1:0] pos;
  } tick_result_t;

  // Tracks the scanner motion state and the results each tick should give
  class scan_scoreboard;
    logic [oscd_pkg::LIMIT_W-1:0]        limit;
    logic [oscd_pkg::MAXSP_W-1:0]        max_sp;
    logic signed [oscd_pkg::SPEED_W-1:0] init_sp;
    logic signed [oscd_pkg::SPEED_W-1:0] velocity;
    logic signed [oscd_pkg::ANGLE_W-1:0] held;
    bit                                  dir_pos;
    tick_result_t                        due_q[$];
    int                                  ticks;
    int                                  checked;
    int                                  errors;
    int                                  jumps;
    int                                  holds;

    function new();
      limit    = oscd_pkg::ANGLE_LIMIT_RST;
      max_sp   = oscd_pkg::MAX_SPEED_RST;
      init_sp  = signed'(oscd_pkg::INITIAL_SPEED_RST);
      velocity = '0;
      held     = '0;
      dir_pos  = 1'b1;
    endfunction

    function int clip_mag(int v);
      int m;
      m = (v < 0) ? -v : v;
      return (m > 32767) ? 32767 : m;
    endfunction

    function void set_config(logic [oscd_pkg::CFG_IDX_W-1:0] idx,
                             logic [oscd_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        oscd_pkg::REG_ANGLE_LIMIT:   limit = data[oscd_pkg::LIMIT_W-1:0];
        oscd_pkg::REG_MAX_SPEED:     max_sp = data[oscd_pkg::MAXSP_W-1:0];
        oscd_pkg::REG_INITIAL_SPEED: init_sp = $signed(data);
        default: ;
      endcase
    endfunction

    // Apply a speed command: deadband, direction memory, clamp
    function void command_step(int s, int angle_now);
      int prev;
      int lim;
      int v;
      prev = int'(velocity);
      lim  = int'(max_sp);
      if (clip_mag(s) < int'(oscd_pkg::DEADBAND)) begin
        s    = 0;
        held = angle_now[oscd_pkg::ANGLE_W-1:0];
      end
      if (prev != 0 && s == 0) dir_pos = (prev > 0);
      if (s > 0) begin
        v = (s < lim) ? s : lim;
      end else begin
        v = (s > -lim) ? s : -lim;
      end
      if (prev == 0 && s != 0 && !dir_pos) v = -v;
      velocity = v[oscd_pkg::SPEED_W-1:0];
    endfunction

    // Predict the result of one accepted tick and advance the state
    function void predict_tick(logic signed [oscd_pkg::ANGLE_W-1:0] angle,
                               logic signed [oscd_pkg::SPEED_W-1:0] cmd, logic back);
      tick_result_t r;
      int a;
      int c;
      int s;
      int lim;
      int pin;
      a   = int'(angle);
      c   = int'(cmd);
      lim = int'(limit);
      pin = 0;
      r   = '0;
      ticks++;
      if (back) begin
        jumps++;
        command_step(int'(init_sp), a);
        held    = '0;
        dir_pos = 1'b1;
        r.drive = init_sp;
        r.ovr   = 1'b1;
      end else begin
        if (velocity == 0) begin
          holds++;
          r.ovr = 1'b1;
          r.pos = held;
          pin   = int'(held);
        end else if (a >= lim) begin
          velocity = 16'(-clip_mag(int'(velocity)));
        end else if (a <= -lim) begin
          velocity = 16'(clip_mag(int'(velocity)));
        end
        r.drive = velocity;
      end
      s = (c > 0) ? c : 0;
      if (velocity < 0) s = -s;
      command_step(s, r.ovr ? pin : a);
      due_q.push_back(r);
    endfunction

    function void check_tick(tick_result_t got);
      tick_result_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result drive %0d ovr %0b pos %0d", $realtime,
                   got.drive, got.ovr, got.pos);
        return;
      end
      want = due_q.pop_front();
      checked++;
      if (got.drive !== want.drive || got.ovr !== want.ovr || got.pos !== want.pos) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: result %0d differs: drive exp %0d got %0d, ",
                    "ovr exp %0b got %0b, pos exp %0d got %0d"},
                   $realtime, checked, want.drive, got.drive, want.ovr, got.ovr,
                   want.pos, got.pos);
      end
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [oscd_pkg::ANGLE_W-1:0] joint_angle;
  logic signed [oscd_pkg::SPEED_W-1:0] speed_cmd;
  logic                                time_back;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [oscd_pkg::SPEED_W-1:0] velocity_drive;
  logic                                override_valid;
  logic signed [oscd_pkg::ANGLE_W-1:0] position_value;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [oscd_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [oscd_pkg::CFG_DATA_W-1:0]     cfg_data;

  scan_scoreboard sb;
  int             hold_req;
  int             last_cmd;
  int             phases;
  int             idle_cycles;

  oscillating_scan_direction_control dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .joint_angle_i    (joint_angle),
    .speed_cmd_i      (speed_cmd),
    .time_back_i      (time_back),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .velocity_drive_o (velocity_drive),
    .override_valid_o (override_valid),
    .position_value_o (position_value),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note each input transfer and check each output transfer
  always @(posedge clk) begin
    if (rst_n && in_valid && in_stall === 1'b0)
      sb.predict_tick(joint_angle, speed_cmd, time_back);
    if (rst_n && out_valid === 1'b1 && !out_stall)
      sb.check_tick('{velocity_drive, override_valid, position_value});
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)
        || (cfg_valid && cfg_ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output back-pressure: random modes, plus a long hold-off on request
  always @(posedge clk) begin : stall_gen
    int          hold_left;
    int          hold_seen;
    int          mode_left;
    stall_mode_e mode;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
        default:     out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one tick and hold it until the transfer
  task automatic send_tick(logic signed [oscd_pkg::ANGLE_W-1:0] angle,
                           logic signed [oscd_pkg::SPEED_W-1:0] cmd, logic back);
    in_valid    <= 1'b1;
    joint_angle <= angle;
    speed_cmd   <= cmd;
    time_back   <= back;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic pause_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [oscd_pkg::CFG_IDX_W-1:0] idx,
                           logic [oscd_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_config(idx, data);
  endtask

  // Drain, settle, then load all three registers and, on request, poke the unused index
  task automatic load_config(logic [oscd_pkg::CFG_DATA_W-1:0] lim,
                             logic [oscd_pkg::CFG_DATA_W-1:0] maxsp,
                             logic [oscd_pkg::CFG_DATA_W-1:0] init, bit poke_unused);
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(oscd_pkg::REG_ANGLE_LIMIT, lim);
    write_reg(oscd_pkg::REG_MAX_SPEED, maxsp);
    write_reg(oscd_pkg::REG_INITIAL_SPEED, init);
    if (poke_unused) write_reg(REG_UNUSED, 16'($urandom));
    cfg_valid <= 1'b0;
    phases++;
  endtask

  // Sweep-like ticks: angles mostly near the reversal points
  task automatic send_random_tick();
    int lim;
    int ms;
    int sel;
    int angle;
    int cmd;
    lim = int'(sb.limit);
    ms  = int'(sb.max_sp);
    sel = $urandom_range(0, 99);
    if (sel < 38) angle = lim + int'($urandom_range(0, 8)) - 4;
    else if (sel < 76) angle = -lim + int'($urandom_range(0, 8)) - 4;
    else if (sel < 94) angle = int'($urandom_range(0, 2 * lim)) - lim;
    else angle = int'($signed(16'($urandom)));
    sel = $urandom_range(0, 99);
    if (sel < 15) cmd = last_cmd;
    else if (sel < 55) cmd = int'($urandom_range(0, ms + ms / 4 + 8));
    else if (sel < 70) cmd = int'($urandom_range(0, 2 * oscd_pkg::DEADBAND)) - 2;
    else if (sel < 80) cmd = 0;
    else if (sel < 90) cmd = -1 - int'($urandom_range(0, 32767));
    else cmd = int'($signed(16'($urandom)));
    if (cmd > 32767) cmd = 32767;
    last_cmd = cmd;
    send_tick(16'(angle), 16'(cmd), $urandom_range(0, 49) == 0);
  endtask

  // Random ticks in bursts with gaps, now and then waiting for the output to empty
  task automatic send_bursts(int n);
    int burst;
    int sel;
    while (n > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > n) burst = n;
      n -= burst;
      repeat (burst) send_random_tick();
      sel = $urandom_range(0, 39);
      if (sel == 0) drain();
      else if (sel > 10) pause_sender($urandom_range(1, 8));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    sb          = new();
    hold_req    = 0;
    last_cmd    = 0;
    phases      = 1;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    joint_angle <= '0;
    speed_cmd   <= '0;
    time_back   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: deadband edge, reversal at both limits, stop and resume
    send_tick(16'sd0, 16'sd0, 1'b0);
    send_tick(16'sd500, 16'sd3, 1'b0);
    send_tick(16'sd500, 16'sd4, 1'b0);
    send_tick(16'sd6631, 16'sd5000, 1'b0);
    send_tick(-16'sd6631, 16'sd4915, 1'b0);
    send_tick(16'sd100, -16'sd5, 1'b0);
    send_tick(16'sd200, 16'sd100, 1'b0);
    send_tick(16'sd6700, 16'sd0, 1'b0);
    send_tick(16'sd0, 16'sd32767, 1'b0);
    send_tick(16'sh7fff, 16'sh8000, 1'b0);
    send_tick(16'sh8000, 16'sh7fff, 1'b0);
    send_tick(16'sd0, 16'sd200, 1'b1);
    send_bursts(250);

    // Zero limit and zero max speed, most negative initial speed
    load_config(16'd0, 16'd0, 16'h8000, 1'b1);
    send_tick(16'sd0, 16'sd0, 1'b1);
    send_tick(16'sd1, 16'sd100, 1'b0);
    send_tick(-16'sd1, 16'sd100, 1'b1);
    send_bursts(150);

    // Upper bits set on the limit and max speed words; long output hold-off under load
    load_config(16'hffff, 16'hffff, 16'h7fff, 1'b0);
    send_tick(16'sd16383, 16'sd32767, 1'b1);
    send_tick(16'sd16383, 16'sd32767, 1'b0);
    send_tick(-16'sd16383, 16'sd32767, 1'b0);
    send_tick(16'sh7fff, 16'sh7fff, 1'b0);
    hold_req <= hold_req + 1;
    send_bursts(250);

    // Tight limits, initial speed inside the deadband
    load_config(16'd1, 16'd4, 16'd3, 1'b0);
    send_tick(16'sd5, 16'sd10, 1'b1);
    send_tick(16'sd1, 16'sd10, 1'b0);
    send_bursts(200);

    // Random settings, one with fully random register words
    repeat (4) begin
      load_config(16'($urandom_range(0, 12868)), 16'($urandom_range(0, 32767)),
                  16'($urandom), $urandom_range(0, 1) == 1);
      send_bursts(230);
    end
    load_config(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
    send_bursts(230);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d ticks over %0d register settings, %0d results checked",
             sb.ticks, phases, sb.checked);
    $display("run: %0d time jumps, %0d held-angle overrides, %0d errors",
             sb.jumps, sb.holds, sb.errors + sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/oscd_pkg.sv
rtl/oscd_step.sv
rtl/oscillating_scan_direction_control.sv
verif/oscillating_scan_direction_control_tb.sv
